// ===== hw/rtl/trs_pkg.sv =====
// ----------------------------------------------------------------------------
// trs_pkg
// Shared types, codes and constants of the ranging responder sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package trs_pkg;

    localparam int unsigned STAMP_W = 40;
    localparam int unsigned CFG_W   = 16;

    // Event codes on the input channel
    localparam logic [2:0] ACT_START   = 3'd0;
    localparam logic [2:0] ACT_FRAME   = 3'd1;
    localparam logic [2:0] ACT_RX_ERR  = 3'd2;
    localparam logic [2:0] ACT_TX_DONE = 3'd3;
    localparam logic [2:0] ACT_ABORT   = 3'd4;

    // Radio commands on the output channel
    localparam logic [2:0] CMD_NONE      = 3'd0;
    localparam logic [2:0] CMD_ARM_POLL  = 3'd1;
    localparam logic [2:0] CMD_SEND_RESP = 3'd2;
    localparam logic [2:0] CMD_SEND_RPT  = 3'd3;
    localparam logic [2:0] CMD_RADIO_OFF = 3'd4;

    // Done status
    localparam logic [1:0] DONE_NONE      = 2'd0;
    localparam logic [1:0] DONE_SECONDARY = 2'd1;
    localparam logic [1:0] DONE_MASTER    = 2'd2;

    // Frame types and ids
    localparam logic [7:0] TYPE_POLL   = 8'hAB;
    localparam logic [7:0] TYPE_RESP   = 8'hBC;
    localparam logic [7:0] TYPE_FINAL  = 8'hCD;
    localparam logic [7:0] TYPE_REPORT = 8'hDE;
    localparam logic [7:0] MASTER_ID   = 8'hFF;

    // Configuration register indexes and reset values
    localparam logic [1:0] CFG_OWN_ID        = 2'd0;
    localparam logic [1:0] CFG_POLL_TIMEOUT  = 2'd1;
    localparam logic [1:0] CFG_FINAL_TIMEOUT = 2'd2;

    localparam logic [7:0]  OWN_ID_RST        = 8'd0;
    localparam logic [15:0] POLL_TIMEOUT_RST  = 16'd11000;
    localparam logic [15:0] FINAL_TIMEOUT_RST = 16'd9500;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_POLL   = 2'd1,
        PH_FINAL  = 2'd2,
        PH_TXDONE = 2'd3
    } phase_t;

    typedef struct packed {
        logic [7:0]  own_id;
        logic [15:0] poll_timeout;
        logic [15:0] final_timeout;
    } cfg_t;

    typedef struct packed {
        logic [2:0]         action;
        logic [7:0]         src_id;
        logic [7:0]         dst_id;
        logic [7:0]         frame_type;
        logic [7:0]         mode_byte;
        logic [STAMP_W-1:0] rx_stamp;
        logic [STAMP_W-1:0] tx_stamp;
    } evt_item_t;

    typedef struct packed {
        logic [2:0]         command;
        logic [7:0]         dest_out;
        logic [7:0]         seq_out;
        logic [7:0]         type_out;
        logic [STAMP_W-1:0] stamp_first;
        logic [STAMP_W-1:0] stamp_second;
        logic [15:0]        timeout_out;
        logic [1:0]         done_res;
        logic [7:0]         mode_out;
    } cmd_item_t;

endpackage

`default_nettype wire

// ===== hw/rtl/trs_evt_if.sv =====
// ----------------------------------------------------------------------------
// trs_evt_if
// Radio event channel: valid/ready handshake with the event fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface trs_evt_if;
    logic                        valid;
    logic                        ready;
    logic [2:0]                  action;
    logic [7:0]                  src_id;
    logic [7:0]                  dst_id;
    logic [7:0]                  frame_type;
    logic [7:0]                  mode_byte;
    logic [trs_pkg::STAMP_W-1:0] rx_stamp;
    logic [trs_pkg::STAMP_W-1:0] tx_stamp;

    modport source (
        output valid, action, src_id, dst_id, frame_type, mode_byte, rx_stamp, tx_stamp,
        input  ready
    );

    modport sink (
        input  valid, action, src_id, dst_id, frame_type, mode_byte, rx_stamp, tx_stamp,
        output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/trs_cmd_if.sv =====
// ----------------------------------------------------------------------------
// trs_cmd_if
// Radio command channel: valid/ready handshake with the result fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface trs_cmd_if;
    logic                        valid;
    logic                        ready;
    logic [2:0]                  command;
    logic [7:0]                  dest_out;
    logic [7:0]                  seq_out;
    logic [7:0]                  type_out;
    logic [trs_pkg::STAMP_W-1:0] stamp_first;
    logic [trs_pkg::STAMP_W-1:0] stamp_second;
    logic [15:0]                 timeout_out;
    logic [1:0]                  done_res;
    logic [7:0]                  mode_out;

    modport source (
        output valid, command, dest_out, seq_out, type_out, stamp_first, stamp_second,
               timeout_out, done_res, mode_out,
        input  ready
    );

    modport sink (
        input  valid, command, dest_out, seq_out, type_out, stamp_first, stamp_second,
               timeout_out, done_res, mode_out,
        output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/trs_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// trs_cfg_regs
// Configuration register file: own id and the two receive timeouts.
// ----------------------------------------------------------------------------
`default_nettype none

module trs_cfg_regs (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [1:0]                cfg_index,
    input  wire logic [trs_pkg::CFG_W-1:0] cfg_data,
    output trs_pkg::cfg_t                  cfg
);

    trs_pkg::cfg_t cfg_reg;
    trs_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                trs_pkg::CFG_OWN_ID:        cfg_next.own_id        = cfg_data[7:0];
                trs_pkg::CFG_POLL_TIMEOUT:  cfg_next.poll_timeout  = cfg_data;
                trs_pkg::CFG_FINAL_TIMEOUT: cfg_next.final_timeout = cfg_data;
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.own_id        <= trs_pkg::OWN_ID_RST;
            cfg_reg.poll_timeout  <= trs_pkg::POLL_TIMEOUT_RST;
            cfg_reg.final_timeout <= trs_pkg::FINAL_TIMEOUT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/trs_fsm.sv =====
// ----------------------------------------------------------------------------
// trs_fsm
// Ranging exchange state: phase, sequence, last mode and last peer. Turns
// one event into one radio command in the cycle it is stepped.
// ----------------------------------------------------------------------------
`default_nettype none

module trs_fsm (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               step,
    input  wire trs_pkg::evt_item_t evt,
    input  wire trs_pkg::cfg_t      cfg,
    output trs_pkg::cmd_item_t      res
);

    trs_pkg::phase_t phase_reg;
    trs_pkg::phase_t phase_next;
    logic [7:0]      seq_reg;
    logic [7:0]      seq_next;
    logic [7:0]      mode_reg;
    logic [7:0]      mode_next;
    logic [7:0]      peer_reg;
    logic [7:0]      peer_next;

    logic poll_match;
    logic final_match;

    assign poll_match  = (evt.frame_type == trs_pkg::TYPE_POLL)  && (evt.dst_id == cfg.own_id);
    assign final_match = (evt.frame_type == trs_pkg::TYPE_FINAL) && (evt.dst_id == cfg.own_id);

    // Next state
    always_comb
    begin
        phase_next = phase_reg;
        seq_next   = seq_reg;
        mode_next  = mode_reg;
        peer_next  = peer_reg;
        unique case (evt.action)
            trs_pkg::ACT_START:
            begin
                phase_next = trs_pkg::PH_POLL;
            end
            trs_pkg::ACT_FRAME:
            begin
                if (phase_reg == trs_pkg::PH_POLL)
                begin
                    if (poll_match)
                    begin
                        if (evt.src_id == trs_pkg::MASTER_ID)
                            mode_next = evt.mode_byte;
                        peer_next  = evt.src_id;
                        phase_next = trs_pkg::PH_FINAL;
                    end
                    else
                    begin
                        phase_next = trs_pkg::PH_POLL;
                    end
                end
                else if (phase_reg == trs_pkg::PH_FINAL)
                begin
                    // sequence moves on for any outcome of the final wait
                    seq_next = seq_reg + 8'd1;
                    if (final_match)
                    begin
                        peer_next  = evt.src_id;
                        phase_next = trs_pkg::PH_TXDONE;
                    end
                    else
                    begin
                        phase_next = trs_pkg::PH_POLL;
                    end
                end
            end
            trs_pkg::ACT_RX_ERR:
            begin
                if (phase_reg == trs_pkg::PH_POLL)
                begin
                    phase_next = trs_pkg::PH_POLL;
                end
                else if (phase_reg == trs_pkg::PH_FINAL)
                begin
                    seq_next   = seq_reg + 8'd1;
                    phase_next = trs_pkg::PH_POLL;
                end
            end
            trs_pkg::ACT_TX_DONE:
            begin
                if (phase_reg == trs_pkg::PH_TXDONE)
                    phase_next = trs_pkg::PH_POLL;
            end
            trs_pkg::ACT_ABORT:
            begin
                phase_next = trs_pkg::PH_IDLE;
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        res          = '0;
        res.mode_out = mode_next;
        unique case (evt.action)
            trs_pkg::ACT_START:
            begin
                res.command     = trs_pkg::CMD_ARM_POLL;
                res.timeout_out = cfg.poll_timeout;
            end
            trs_pkg::ACT_FRAME:
            begin
                if (phase_reg == trs_pkg::PH_POLL && poll_match)
                begin
                    res.command     = trs_pkg::CMD_SEND_RESP;
                    res.dest_out    = evt.src_id;
                    res.seq_out     = seq_reg;
                    res.type_out    = trs_pkg::TYPE_RESP;
                    res.stamp_first = evt.rx_stamp;
                    res.timeout_out = cfg.final_timeout;
                end
                else if (phase_reg == trs_pkg::PH_FINAL && final_match)
                begin
                    res.command      = trs_pkg::CMD_SEND_RPT;
                    res.dest_out     = evt.src_id;
                    res.type_out     = trs_pkg::TYPE_REPORT;
                    res.stamp_first  = evt.tx_stamp;
                    res.stamp_second = evt.rx_stamp;
                end
                else if (phase_reg == trs_pkg::PH_POLL || phase_reg == trs_pkg::PH_FINAL)
                begin
                    res.command     = trs_pkg::CMD_ARM_POLL;
                    res.timeout_out = cfg.poll_timeout;
                end
            end
            trs_pkg::ACT_RX_ERR:
            begin
                if (phase_reg == trs_pkg::PH_POLL || phase_reg == trs_pkg::PH_FINAL)
                begin
                    res.command     = trs_pkg::CMD_ARM_POLL;
                    res.timeout_out = cfg.poll_timeout;
                end
            end
            trs_pkg::ACT_TX_DONE:
            begin
                if (phase_reg == trs_pkg::PH_TXDONE)
                begin
                    res.done_res    = (peer_reg == trs_pkg::MASTER_ID) ?
                                      trs_pkg::DONE_MASTER : trs_pkg::DONE_SECONDARY;
                    res.command     = trs_pkg::CMD_ARM_POLL;
                    res.timeout_out = cfg.poll_timeout;
                end
            end
            trs_pkg::ACT_ABORT:
            begin
                res.command = trs_pkg::CMD_RADIO_OFF;
            end
            default:
            begin
                res.command = trs_pkg::CMD_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= trs_pkg::PH_IDLE;
            seq_reg   <= 8'd0;
            mode_reg  <= 8'd0;
            peer_reg  <= 8'd0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            seq_reg   <= seq_next;
            mode_reg  <= mode_next;
            peer_reg  <= peer_next;
        end
    end

    a_report_to_txdone: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.command == trs_pkg::CMD_SEND_RPT |=> phase_reg == trs_pkg::PH_TXDONE)
        else $error("report sent without entering tx done wait");

    a_done_from_txdone: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.done_res != trs_pkg::DONE_NONE |-> phase_reg == trs_pkg::PH_TXDONE)
        else $error("done status outside tx done wait");

    a_arm_to_poll: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.command == trs_pkg::CMD_ARM_POLL |=> phase_reg == trs_pkg::PH_POLL)
        else $error("poll receive armed but phase is not wait poll");

    a_seq_in_final: assert property (@(posedge clk) disable iff (!rst_n)
        step && seq_next != seq_reg |-> phase_reg == trs_pkg::PH_FINAL)
        else $error("sequence moved outside the final wait");

endmodule

`default_nettype wire

// ===== hw/rtl/twr_responder_sequencer.sv =====
// ----------------------------------------------------------------------------
// twr_responder_sequencer
// Tag-side sequencer for double-sided two-way ranging.
// ----------------------------------------------------------------------------
// Usage:
//   radio_evt carries one radio event per transaction (start, good frame,
//   rx timeout/error, tx done, abort) with the frame header bytes and the
//   rx/tx timestamps. radio_cmd returns exactly one command per event: the
//   radio command, the header and timestamps of the frame to send, the rx
//   timeout to program, the done status and the last captured mode byte.
//   cfg_we/cfg_index/cfg_data write own id, poll timeout and final timeout;
//   write them only while no event is in flight.
//   The event register feeds the sequencer, whose result loads the command
//   register. Throughput is one event per cycle while radio_cmd is not
//   stalled; the state update is a single pass.
//   A stalled radio_cmd holds its command; the event register still takes
//   one more event, then radio_evt.ready drops until the command is taken.
//   Reset clears the phase to idle, sequence, mode and peer to zero, and
//   loads the configuration defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module twr_responder_sequencer (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    trs_evt_if.sink                        radio_evt,
    trs_cmd_if.source                      radio_cmd,
    input  wire logic                      cfg_we,
    input  wire logic [1:0]                cfg_index,
    input  wire logic [trs_pkg::CFG_W-1:0] cfg_data
);

    trs_pkg::cfg_t      cfg;
    trs_pkg::evt_item_t evt_in;
    trs_pkg::cmd_item_t res;

    logic               evt_valid_reg;
    logic               evt_valid_next;
    trs_pkg::evt_item_t evt_item_reg;
    logic               cmd_valid_reg;
    logic               cmd_valid_next;
    trs_pkg::cmd_item_t cmd_item_reg;

    logic advance;
    logic evt_take;

    trs_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    trs_fsm u_fsm (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .evt   (evt_item_reg),
        .cfg   (cfg),
        .res   (res)
    );

    assign evt_in.action     = radio_evt.action;
    assign evt_in.src_id     = radio_evt.src_id;
    assign evt_in.dst_id     = radio_evt.dst_id;
    assign evt_in.frame_type = radio_evt.frame_type;
    assign evt_in.mode_byte  = radio_evt.mode_byte;
    assign evt_in.rx_stamp   = radio_evt.rx_stamp;
    assign evt_in.tx_stamp   = radio_evt.tx_stamp;

    // event moves on when the command register is empty or being drained
    assign advance  = evt_valid_reg && (!cmd_valid_reg || radio_cmd.ready);
    assign evt_take = radio_evt.valid && radio_evt.ready;

    assign radio_evt.ready = !evt_valid_reg || advance;

    assign evt_valid_next = evt_take || (evt_valid_reg && !advance);
    assign cmd_valid_next = advance || (cmd_valid_reg && !radio_cmd.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            evt_valid_reg <= 1'b0;
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            evt_valid_reg <= evt_valid_next;
            cmd_valid_reg <= cmd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt_take)
            evt_item_reg <= evt_in;
        if (advance)
            cmd_item_reg <= res;
    end

    assign radio_cmd.valid        = cmd_valid_reg;
    assign radio_cmd.command      = cmd_item_reg.command;
    assign radio_cmd.dest_out     = cmd_item_reg.dest_out;
    assign radio_cmd.seq_out      = cmd_item_reg.seq_out;
    assign radio_cmd.type_out     = cmd_item_reg.type_out;
    assign radio_cmd.stamp_first  = cmd_item_reg.stamp_first;
    assign radio_cmd.stamp_second = cmd_item_reg.stamp_second;
    assign radio_cmd.timeout_out  = cmd_item_reg.timeout_out;
    assign radio_cmd.done_res     = cmd_item_reg.done_res;
    assign radio_cmd.mode_out     = cmd_item_reg.mode_out;

    a_evt_kept: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid_reg && !advance |=> evt_valid_reg && $stable(evt_item_reg))
        else $error("pending event dropped before it was processed");

    a_cmd_kept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid_reg && !radio_cmd.ready |=> cmd_valid_reg && $stable(cmd_item_reg))
        else $error("stalled command lost or changed");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        advance |-> !cmd_valid_reg || radio_cmd.ready)
        else $error("command register overwritten while full");

endmodule

`default_nettype wire
